### src/three_sensor_line_follow_fsm_defines.svh
// Assertion macros used by the line follower back end (tslf_back).
`ifndef THREE_SENSOR_LINE_FOLLOW_FSM_DEFINES_SVH
`define THREE_SENSOR_LINE_FOLLOW_FSM_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TSLF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tslf assertion failed");
// next-cycle implication
`define TSLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tslf assertion failed");
`else
`define TSLF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TSLF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### src/tslf_pkg.sv
`timescale 1ns / 1ps

package tslf_pkg;

    // datapath widths
    localparam int SAMPLE_BITS    = 12;
    localparam int COUNT_BITS     = 16;
    localparam int TIMER_BITS     = 16;

    // register widths
    localparam int LINE_TH_BITS   = 12;
    localparam int LIFT_TH_BITS   = 12;
    localparam int LIMIT_BITS     = 16;
    localparam int HINT_TICK_BITS = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_IDX_BITS   = 2;

    // compare widths wide enough for both operands
    localparam int LINE_CMP_BITS  = (SAMPLE_BITS > LINE_TH_BITS) ? SAMPLE_BITS : LINE_TH_BITS;
    localparam int LIFT_CMP_BITS  = (SAMPLE_BITS > LIFT_TH_BITS) ? SAMPLE_BITS : LIFT_TH_BITS;
    localparam int LOST_CMP_BITS  = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
    localparam int TMR_CMP_BITS   = (TIMER_BITS > HINT_TICK_BITS) ? TIMER_BITS : HINT_TICK_BITS;

    // register reset values
    localparam logic [LINE_TH_BITS-1:0]   LINE_TH_RST    = LINE_TH_BITS'(1000);
    localparam logic [LIFT_TH_BITS-1:0]   LIFT_TH_RST    = LIFT_TH_BITS'(100);
    localparam logic [LIMIT_BITS-1:0]     LOST_LIMIT_RST = LIMIT_BITS'(100);
    localparam logic [HINT_TICK_BITS-1:0] HINT_TICK_RST  = HINT_TICK_BITS'(2000);

    // command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CLS_LOST     = 2'd0,
        CLS_FWD      = 2'd1,
        CLS_AT_RIGHT = 2'd2,
        CLS_AT_LEFT  = 2'd3
    } t_move_class;

    typedef enum logic [1:0] {
        STEER_CENTER = 2'd0,
        STEER_RIGHT  = 2'd1,
        STEER_LEFT   = 2'd2,
        STEER_HOLD   = 2'd3
    } t_steer;

    typedef enum logic [1:0] {
        HINT_NONE  = 2'd0,
        HINT_RIGHT = 2'd1,
        HINT_LEFT  = 2'd2
    } t_hint;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LINE_TH    = 2'd0,
        CFG_LIFT_TH    = 2'd1,
        CFG_LOST_LIMIT = 2'd2,
        CFG_HINT_TICKS = 2'd3
    } t_cfg_idx;

    // configuration write as seen by the submodules
    typedef struct packed {
        logic                     we;
        t_cfg_idx                 idx;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    // classified command passed from front to back
    typedef struct packed {
        t_op         op;
        t_move_class cls;
        logic        lifted;
    } t_cmd;

endpackage

### src/tslf_in_if.sv
`timescale 1ns / 1ps

interface tslf_in_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [tslf_pkg::SAMPLE_BITS-1:0] left_sample;
    logic [tslf_pkg::SAMPLE_BITS-1:0] center_sample;
    logic [tslf_pkg::SAMPLE_BITS-1:0] right_sample;

    modport source (
        output valid, op, left_sample, center_sample, right_sample,
        input  ready
    );
    modport sink (
        input  valid, op, left_sample, center_sample, right_sample,
        output ready
    );
endinterface

### src/tslf_out_if.sv
`timescale 1ns / 1ps

interface tslf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] move_class;
    logic [1:0] steer_cmd;
    logic       motor_stop;
    logic [1:0] turn_hint;
    logic       route_done;

    modport source (
        output valid, move_class, steer_cmd, motor_stop, turn_hint, route_done,
        input  ready
    );
    modport sink (
        input  valid, move_class, steer_cmd, motor_stop, turn_hint, route_done,
        output ready
    );
endinterface

### src/tslf_front.sv
`timescale 1ns / 1ps

module tslf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tslf_pkg::t_cfg_wr i_cfg,
    tslf_in_if.sink           i_in,
    input  logic              i_q_ready,
    output logic              o_push,
    output tslf_pkg::t_cmd    o_cmd
);
    import tslf_pkg::*;

    logic [LINE_TH_BITS-1:0] r_line_th;
    logic [LIFT_TH_BITS-1:0] r_lift_th;
    logic                    see_l, see_c, see_r;
    logic                    low_l, low_c, low_r;
    t_move_class             cls;

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_th <= LINE_TH_RST;
            r_lift_th <= LIFT_TH_RST;
        end else if (i_cfg.we) begin
            if (i_cfg.idx == CFG_LINE_TH) begin
                r_line_th <= i_cfg.data[LINE_TH_BITS-1:0];
            end
            if (i_cfg.idx == CFG_LIFT_TH) begin
                r_lift_th <= i_cfg.data[LIFT_TH_BITS-1:0];
            end
        end
    end

    // per-sensor line and lift compares
    assign see_l = LINE_CMP_BITS'(i_in.left_sample)   < LINE_CMP_BITS'(r_line_th);
    assign see_c = LINE_CMP_BITS'(i_in.center_sample) < LINE_CMP_BITS'(r_line_th);
    assign see_r = LINE_CMP_BITS'(i_in.right_sample)  < LINE_CMP_BITS'(r_line_th);
    assign low_l = LIFT_CMP_BITS'(i_in.left_sample)   <= LIFT_CMP_BITS'(r_lift_th);
    assign low_c = LIFT_CMP_BITS'(i_in.center_sample) <= LIFT_CMP_BITS'(r_lift_th);
    assign low_r = LIFT_CMP_BITS'(i_in.right_sample)  <= LIFT_CMP_BITS'(r_lift_th);

    // pattern to move class, first match wins
    always_comb begin
        priority if (!see_l && !see_c && !see_r) begin
            cls = CLS_LOST;
        end else if (!see_l && see_c && see_r) begin
            cls = CLS_AT_RIGHT;
        end else if (see_l && see_c && !see_r) begin
            cls = CLS_AT_LEFT;
        end else if (see_c) begin
            cls = CLS_FWD;
        end else if (see_r) begin
            cls = CLS_AT_RIGHT;
        end else begin
            cls = CLS_AT_LEFT;
        end
    end

    // transfer into the command queue
    assign i_in.ready   = i_q_ready;
    assign o_push       = i_in.valid && i_q_ready;
    assign o_cmd.op     = t_op'(i_in.op);
    assign o_cmd.cls    = cls;
    assign o_cmd.lifted = low_l && low_c && low_r;

endmodule

### src/tslf_queue.sv
`timescale 1ns / 1ps

module tslf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tslf_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output tslf_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import tslf_pkg::*;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;

    assign o_ready = r_count != QCNT_BITS'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // occupancy
    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCNT_BITS'(1);
            2'b01:   n_count = r_count - QCNT_BITS'(1);
            default: n_count = r_count;
        endcase
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

### src/tslf_back.sv
`timescale 1ns / 1ps
`include "three_sensor_line_follow_fsm_defines.svh"

module tslf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tslf_pkg::t_cfg_wr i_cfg,
    input  logic              i_valid,
    input  tslf_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    tslf_out_if.source        o_out
);
    import tslf_pkg::*;

    // configuration
    logic [LIMIT_BITS-1:0]     r_lost_limit;
    logic [HINT_TICK_BITS-1:0] r_hint_ticks;

    // route state
    logic                  r_done,     n_done;
    logic [COUNT_BITS-1:0] r_lost_cnt, n_lost_cnt;
    t_move_class           r_prev,     n_prev;
    t_move_class           r_track,    n_track;
    logic [TIMER_BITS-1:0] r_elapsed,  n_elapsed;

    // output register
    logic        r_out_valid, n_out_valid;
    t_move_class r_cls,       n_cls;
    t_steer      r_steer,     n_steer;
    logic        r_stop,      n_stop;
    t_hint       r_hint,      n_hint;
    logic        r_route_done, n_route_done;

    logic                  take;
    logic                  done_now;
    logic                  turn_start;
    logic [TIMER_BITS-1:0] el_eff;

    // a tick never needs the output slot
    assign take  = i_valid && (i_cmd.op == OP_TICK || !r_out_valid || o_out.ready);
    assign o_pop = take;

    assign done_now = r_done ||
                      (LOST_CMP_BITS'(r_lost_cnt) >= LOST_CMP_BITS'(r_lost_limit));
    assign turn_start = (i_cmd.cls == CLS_AT_RIGHT || i_cmd.cls == CLS_AT_LEFT) &&
                        (r_track != i_cmd.cls);
    assign el_eff = turn_start ? '0 : r_elapsed;

    // command execution
    always_comb begin
        n_done       = r_done;
        n_lost_cnt   = r_lost_cnt;
        n_prev       = r_prev;
        n_track      = r_track;
        n_elapsed    = r_elapsed;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_cls        = r_cls;
        n_steer      = r_steer;
        n_stop       = r_stop;
        n_hint       = r_hint;
        n_route_done = r_route_done;

        if (take && i_cmd.op == OP_TICK) begin
            if (r_elapsed != '1) begin
                n_elapsed = r_elapsed + TIMER_BITS'(1);
            end
        end else if (take) begin
            n_out_valid = 1'b1;
            if (done_now) begin
                n_done       = 1'b1;
                n_cls        = CLS_LOST;
                n_steer      = STEER_HOLD;
                n_stop       = 1'b0;
                n_hint       = HINT_NONE;
                n_route_done = 1'b1;
            end else begin
                n_cls        = i_cmd.cls;
                n_stop       = 1'b0;
                n_hint       = HINT_NONE;
                n_route_done = 1'b0;
                n_prev       = i_cmd.cls;

                // steering, search after the previous class when lost
                unique case (i_cmd.cls)
                    CLS_LOST: begin
                        if (r_lost_cnt != '1) begin
                            n_lost_cnt = r_lost_cnt + COUNT_BITS'(1);
                        end
                        n_stop = i_cmd.lifted;
                        unique case (r_prev)
                            CLS_AT_RIGHT: n_steer = STEER_RIGHT;
                            CLS_AT_LEFT:  n_steer = STEER_LEFT;
                            default:      n_steer = STEER_HOLD;
                        endcase
                    end
                    CLS_AT_RIGHT: begin
                        n_lost_cnt = '0;
                        n_steer    = STEER_RIGHT;
                    end
                    CLS_AT_LEFT: begin
                        n_lost_cnt = '0;
                        n_steer    = STEER_LEFT;
                    end
                    default: begin
                        n_lost_cnt = '0;
                        n_steer    = STEER_CENTER;
                    end
                endcase

                // turn timer and hint
                n_elapsed = el_eff;
                n_track   = turn_start ? i_cmd.cls : r_track;
                if (TMR_CMP_BITS'(el_eff) > TMR_CMP_BITS'(r_hint_ticks)) begin
                    n_track = CLS_LOST;
                    if (i_cmd.cls == CLS_AT_RIGHT) begin
                        n_hint = HINT_RIGHT;
                    end else if (i_cmd.cls == CLS_AT_LEFT) begin
                        n_hint = HINT_LEFT;
                    end
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost_limit <= LOST_LIMIT_RST;
            r_hint_ticks <= HINT_TICK_RST;
        end else if (i_cfg.we) begin
            if (i_cfg.idx == CFG_LOST_LIMIT) begin
                r_lost_limit <= i_cfg.data[LIMIT_BITS-1:0];
            end
            if (i_cfg.idx == CFG_HINT_TICKS) begin
                r_hint_ticks <= i_cfg.data[HINT_TICK_BITS-1:0];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b0;
            r_lost_cnt  <= '0;
            r_prev      <= CLS_LOST;
            r_track     <= CLS_LOST;
            r_elapsed   <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_done      <= n_done;
            r_lost_cnt  <= n_lost_cnt;
            r_prev      <= n_prev;
            r_track     <= n_track;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_cls        <= n_cls;
        r_steer      <= n_steer;
        r_stop       <= n_stop;
        r_hint       <= n_hint;
        r_route_done <= n_route_done;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.move_class = r_cls;
    assign o_out.steer_cmd  = r_steer;
    assign o_out.motor_stop = r_stop;
    assign o_out.turn_hint  = r_hint;
    assign o_out.route_done = r_route_done;

    // checks
    `TSLF_ASSERT_IMPL(a_done_payload, i_clk, i_rst_n, r_out_valid && r_route_done, r_cls == CLS_LOST && r_steer == STEER_HOLD && !r_stop && r_hint == HINT_NONE)
    `TSLF_ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n, r_done, r_done)
    `TSLF_ASSERT_IMPL(a_stop_lost, i_clk, i_rst_n, r_out_valid && r_stop, r_cls == CLS_LOST)
    `TSLF_ASSERT_IMPL(a_hint_right, i_clk, i_rst_n, r_out_valid && r_hint == HINT_RIGHT, r_cls == CLS_AT_RIGHT)

endmodule

### src/three_sensor_line_follow_fsm.sv
`timescale 1ns / 1ps
// Three-sensor line follower decision block.
// Input channel i_in carries either a sensor sample (op 0: left, center and
// right grayscale readings) or a one-millisecond tick (op 1). Each sample
// yields one result on o_out (move class, steering command, motor stop,
// turn hint, route done); a tick yields nothing and only advances the turn
// timer. The user must write thresholds, lost limit and hint time on the cfg
// port (i_cfg_wr_en, i_cfg_index, i_cfg_data) only while the block is idle;
// the block does not enforce this. A sample accepted on i_in is written into
// the queue, then taken into the output register that drives o_out.
// Throughput: one item per cycle unless o_out stalls; the front classifies
// and pushes into a two-entry queue, the back executes one queued command
// per cycle. A tick is executed even while the output waits; a sample needs
// the output register to be free or taken in the same cycle.
// Reset (synchronous, active low) restores the register defaults, clears the
// lost count and done flag, and saturates the turn timer.
// When the receiver stalls, the result is held, the queue fills, and after
// two more items i_in.ready drops until the output is taken.
module three_sensor_line_follow_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [tslf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [tslf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    tslf_in_if.sink                             i_in,
    tslf_out_if.source                          o_out
);
    import tslf_pkg::*;

    t_cfg_wr cfg;
    logic    q_ready;
    logic    push;
    t_cmd    push_cmd;
    logic    q_valid;
    t_cmd    q_cmd;
    logic    pop;

    assign cfg.we   = i_cfg_wr_en;
    assign cfg.idx  = t_cfg_idx'(i_cfg_index);
    assign cfg.data = i_cfg_data;

    // classify and enqueue
    tslf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    // decoupling queue
    tslf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    // route state and result register
    tslf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

### tb/tb_three_sensor_line_follow_fsm.sv
`timescale 1ns / 1ps

module tb_three_sensor_line_follow_fsm;
    import tslf_pkg::*;

    // one input item: sample readings or a millisecond tick
    typedef struct packed {
        t_op                    op;
        logic [SAMPLE_BITS-1:0] l_smp;
        logic [SAMPLE_BITS-1:0] c_smp;
        logic [SAMPLE_BITS-1:0] r_smp;
    } t_sensor_item;

    // one navigation result
    typedef struct packed {
        t_move_class cls;
        t_steer      steer;
        logic        stop;
        t_hint       hint;
        logic        done;
    } t_nav_res;

    // directed script rows; ROW_CHK rows carry a hand-written result
    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_SMP,
        ROW_CHK,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] a, b, c;
        t_nav_res    want;
    } t_dir_row;

    localparam t_nav_res NO_RES = '{CLS_LOST, STEER_CENTER, 1'b0, HINT_NONE, 1'b0};
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 200;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    tslf_in_if  in_if ();
    tslf_out_if out_if ();

    three_sensor_line_follow_fsm u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // register shadow
    logic [LINE_TH_BITS-1:0]   line_th    = LINE_TH_RST;
    logic [LIFT_TH_BITS-1:0]   lift_th    = LIFT_TH_RST;
    logic [LIMIT_BITS-1:0]     lost_lim   = LOST_LIMIT_RST;
    logic [HINT_TICK_BITS-1:0] hint_ticks = HINT_TICK_RST;

    // follower state; track_cls of CLS_LOST means no turn tracked
    logic                  done_q    = 1'b0;
    logic [COUNT_BITS-1:0] lost_cnt  = '0;
    t_move_class           last_cls  = CLS_LOST;
    t_move_class           track_cls = CLS_LOST;
    logic [TIMER_BITS-1:0] turn_age  = '1;

    t_nav_res nav_expect_q [$];
    int       fail_cnt      = 0;
    int       in_gap_max    = 0;
    int       out_stall_max = 0;
    int       hold_req      = 0;

    // stimulus generator state
    logic [2:0] lean_pat = 3'b010;
    int         lost_run = 0;

    t_dir_row dir_rows [35] = '{
        // after reset: ticks on a saturated timer, then plain lost and forward
        '{ROW_TICK, 16'd0,    16'd0,    16'd0,    NO_RES},
        '{ROW_TICK, 16'd0,    16'd0,    16'd0,    NO_RES},
        '{ROW_CHK,  16'd4095, 16'd4095, 16'd4095,
          '{CLS_LOST, STEER_HOLD, 1'b0, HINT_NONE, 1'b0}},
        '{ROW_CHK,  16'd0,    16'd0,    16'd0,
          '{CLS_FWD, STEER_CENTER, 1'b0, HINT_NONE, 1'b0}},
        // every pattern but all three seen, at the threshold boundary, search after each side
        '{ROW_SMP,  16'd999,  16'd1000, 16'd999,  NO_RES},
        '{ROW_SMP,  16'd1000, 16'd999,  16'd999,  NO_RES},
        '{ROW_SMP,  16'd4095, 16'd4095, 16'd4095, NO_RES},
        '{ROW_SMP,  16'd999,  16'd999,  16'd1000, NO_RES},
        '{ROW_SMP,  16'd999,  16'd4095, 16'd4095, NO_RES},
        '{ROW_SMP,  16'd4095, 16'd4095, 16'd4095, NO_RES},
        '{ROW_SMP,  16'd4095, 16'd0,    16'd4095, NO_RES},
        '{ROW_SMP,  16'd4095, 16'd4095, 16'd0,    NO_RES},
        // nothing ever sees the line, everything counts as lifted
        '{ROW_REG,  16'(CFG_LINE_TH),    16'd0,    16'd0, NO_RES},
        '{ROW_REG,  16'(CFG_LIFT_TH),    16'd4095, 16'd0, NO_RES},
        '{ROW_SMP,  16'd0,    16'd0,    16'd0,    NO_RES},
        '{ROW_SMP,  16'd4095, 16'd4095, 16'd4095, NO_RES},
        // widest line window, lift only at zero
        '{ROW_REG,  16'(CFG_LINE_TH),    16'd4095, 16'd0, NO_RES},
        '{ROW_REG,  16'(CFG_LIFT_TH),    16'd0,    16'd0, NO_RES},
        '{ROW_SMP,  16'd4094, 16'd4094, 16'd4094, NO_RES},
        '{ROW_SMP,  16'd4095, 16'd4095, 16'd4095, NO_RES},
        '{ROW_SMP,  16'd0,    16'd0,    16'd0,    NO_RES},
        // turn hints with a zero hint time, both sides
        '{ROW_REG,  16'(CFG_HINT_TICKS), 16'd0,    16'd0, NO_RES},
        '{ROW_SMP,  16'd0,    16'd4095, 16'd4095, NO_RES},
        '{ROW_TICK, 16'd0,    16'd0,    16'd0,    NO_RES},
        '{ROW_SMP,  16'd0,    16'd4095, 16'd4095, NO_RES},
        '{ROW_SMP,  16'd4095, 16'd4095, 16'd0,    NO_RES},
        '{ROW_TICK, 16'd0,    16'd0,    16'd0,    NO_RES},
        '{ROW_SMP,  16'd4095, 16'd4095, 16'd0,    NO_RES},
        '{ROW_TICK, 16'd0,    16'd0,    16'd0,    NO_RES},
        '{ROW_SMP,  16'd0,    16'd0,    16'd0,    NO_RES},
        // count reaches the limit without ending the route, then limit raised
        '{ROW_REG,  16'(CFG_LOST_LIMIT), 16'd1,     16'd0, NO_RES},
        '{ROW_SMP,  16'd4095, 16'd4095, 16'd4095, NO_RES},
        '{ROW_REG,  16'(CFG_LOST_LIMIT), 16'd65535, 16'd0, NO_RES},
        '{ROW_SMP,  16'd4095, 16'd4095, 16'd4095, NO_RES},
        '{ROW_SMP,  16'd0,    16'd0,    16'd0,    NO_RES}
    };

    // {left, center, right} line flags to move class
    function automatic t_move_class pattern_class(input logic [2:0] seen);
        case (seen)
            3'b000:                 return CLS_LOST;
            3'b011, 3'b001, 3'b101: return CLS_AT_RIGHT;
            3'b110, 3'b100:         return CLS_AT_LEFT;
            default:                return CLS_FWD;
        endcase
    endfunction

    // advance the follower state by one item; returns 1 when a result is due
    function automatic bit predict_step(input t_sensor_item it, output t_nav_res res);
        logic [2:0] seen;
        res = NO_RES;
        if (it.op == OP_TICK) begin
            if (turn_age != '1) turn_age++;
            return 1'b0;
        end
        // latched route end
        if (done_q || lost_cnt >= lost_lim) begin
            done_q = 1'b1;
            res = '{CLS_LOST, STEER_HOLD, 1'b0, HINT_NONE, 1'b1};
            return 1'b1;
        end
        seen = {it.l_smp < line_th, it.c_smp < line_th, it.r_smp < line_th};
        res.cls = pattern_class(seen);
        if (res.cls == CLS_LOST) begin
            if (lost_cnt != '1) lost_cnt++;
            res.stop = (it.l_smp <= lift_th) && (it.c_smp <= lift_th) &&
                       (it.r_smp <= lift_th);
            // search toward the side the line was last seen
            if (last_cls == CLS_AT_RIGHT) res.steer = STEER_RIGHT;
            else if (last_cls == CLS_AT_LEFT) res.steer = STEER_LEFT;
            else res.steer = STEER_HOLD;
        end else begin
            lost_cnt = '0;
            if (res.cls == CLS_AT_RIGHT) res.steer = STEER_RIGHT;
            else if (res.cls == CLS_AT_LEFT) res.steer = STEER_LEFT;
            else res.steer = STEER_CENTER;
        end
        // turn timer restarts on a new turn direction
        if ((res.cls == CLS_AT_RIGHT || res.cls == CLS_AT_LEFT) && track_cls != res.cls) begin
            track_cls = res.cls;
            turn_age  = '0;
        end
        if (turn_age > hint_ticks) begin
            if (res.cls == CLS_AT_RIGHT) res.hint = HINT_RIGHT;
            else if (res.cls == CLS_AT_LEFT) res.hint = HINT_LEFT;
            track_cls = CLS_LOST;
        end
        last_cls = res.cls;
        return 1'b1;
    endfunction

    // reading on or off the line under the current thresholds
    function automatic logic [SAMPLE_BITS-1:0] pick_reading(input bit on_line);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (on_line && line_th != '0) begin
            if (pick < 2) return line_th - 1'b1;
            if (pick < 3) return '0;
            return SAMPLE_BITS'($urandom_range(0, int'(line_th) - 1));
        end
        if (pick < 3 && lift_th >= line_th)
            return SAMPLE_BITS'($urandom_range(int'(line_th), int'(lift_th)));
        if (pick < 5) return line_th;
        if (pick < 6) return '1;
        return SAMPLE_BITS'($urandom_range(int'(line_th), 4095));
    endfunction

    // random item; sticky patterns give turns that last, runs of lost
    // samples stop short of the lost limit
    function automatic t_sensor_item next_random_item();
        t_sensor_item it;
        logic [2:0]   pat;
        bit           near_end;
        it.op    = OP_SAMPLE;
        it.l_smp = SAMPLE_BITS'($urandom);
        it.c_smp = SAMPLE_BITS'($urandom);
        it.r_smp = SAMPLE_BITS'($urandom);
        if ($urandom_range(0, 99) < 35) begin
            it.op = OP_TICK;
            return it;
        end
        near_end = (lost_run + 1 >= int'(lost_lim));
        if ($urandom_range(0, 1) == 0) lean_pat = 3'($urandom_range(0, 7));
        pat = (near_end && lean_pat == 3'b000) ? 3'b010 : lean_pat;
        if (near_end || $urandom_range(0, 9) != 0) begin
            it.l_smp = pick_reading(pat[2]);
            it.c_smp = pick_reading(pat[1]);
            it.r_smp = pick_reading(pat[0]);
        end
        if (it.l_smp >= line_th && it.c_smp >= line_th && it.r_smp >= line_th)
            lost_run++;
        else
            lost_run = 0;
        return it;
    endfunction

    // one transfer on the input channel, then predict
    task automatic send_item(input t_sensor_item it, input bit use_typed,
                             input t_nav_res typed_res);
        int       gap;
        t_nav_res res;
        gap = $urandom_range(0, in_gap_max);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.op            <= it.op;
        in_if.left_sample   <= it.l_smp;
        in_if.center_sample <= it.c_smp;
        in_if.right_sample  <= it.r_smp;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        if (predict_step(it, res)) nav_expect_q.push_back(use_typed ? typed_res : res);
    endtask

    // register write once the block has gone idle
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] val);
        in_if.valid <= 1'b0;
        while (nav_expect_q.size() != 0) @(posedge i_clk);
        // a trailing tick may still be in flight
        repeat (4) @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LINE_TH:    line_th    = val[LINE_TH_BITS-1:0];
            CFG_LIFT_TH:    lift_th    = val[LIFT_TH_BITS-1:0];
            CFG_LOST_LIMIT: lost_lim   = val[LIMIT_BITS-1:0];
            CFG_HINT_TICKS: hint_ticks = val[HINT_TICK_BITS-1:0];
            default: ;
        endcase
    endtask

    function automatic void check_field(input string field, input logic [1:0] want,
                                        input logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_cnt++;
        end
    endfunction

    // result side: random stalls, plus one long hold on request
    initial begin : drive_out_ready
        int stall;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req != 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else begin
                stall = $urandom_range(0, out_stall_max);
            end
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_nav_res want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (nav_expect_q.size() == 0) begin
                $error("result transfer with no prediction pending");
                fail_cnt++;
            end else begin
                want = nav_expect_q.pop_front();
                check_field("move_class", want.cls, out_if.move_class);
                check_field("steer_cmd", want.steer, out_if.steer_cmd);
                check_field("motor_stop", {1'b0, want.stop}, {1'b0, out_if.motor_stop});
                check_field("turn_hint", want.hint, out_if.turn_hint);
                check_field("route_done", {1'b0, want.done}, {1'b0, out_if.route_done});
            end
        end
    end

    initial begin : stimulus
        t_sensor_item it;
        int           lim;
        logic [11:0]  th;
        logic [11:0]  lift;
        logic [15:0]  ticks;

        in_if.valid         <= 1'b0;
        in_if.op            <= OP_SAMPLE;
        in_if.left_sample   <= '0;
        in_if.center_sample <= '0;
        in_if.right_sample  <= '0;
        cfg_wr_en           <= 1'b0;
        cfg_index           <= CFG_LINE_TH;
        cfg_data            <= '0;
        i_rst_n             <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed script
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                write_reg(t_cfg_idx'(dir_rows[i].a[CFG_IDX_BITS-1:0]), dir_rows[i].b);
            end else begin
                it.op    = (dir_rows[i].kind == ROW_TICK) ? OP_TICK : OP_SAMPLE;
                it.l_smp = dir_rows[i].a[SAMPLE_BITS-1:0];
                it.c_smp = dir_rows[i].b[SAMPLE_BITS-1:0];
                it.r_smp = dir_rows[i].c[SAMPLE_BITS-1:0];
                send_item(it, dir_rows[i].kind == ROW_CHK, dir_rows[i].want);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    th    = 12'd4095;
                    lift  = 12'd0;
                    lim   = 65535;
                    ticks = 16'd65535;
                end
                1: begin
                    th    = 12'd1;
                    lift  = 12'd4095;
                    lim   = 4;
                    ticks = 16'd0;
                end
                default: begin
                    th    = 12'($urandom_range(1, 4095));
                    lift  = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095)) :
                                                   12'($urandom_range(int'(th), 4095));
                    lim   = $urandom_range(4, 40);
                    ticks = 16'($urandom_range(0, 30));
                end
            endcase
            // keep the route alive during random phases
            if (lim <= int'(lost_cnt) + 1) lim = int'(lost_cnt) + 2;
            write_reg(CFG_LINE_TH, {4'd0, th});
            write_reg(CFG_LIFT_TH, {4'd0, lift});
            write_reg(CFG_LOST_LIMIT, 16'(lim));
            write_reg(CFG_HINT_TICKS, ticks);
            lost_run = int'(lost_cnt);

            case (ph % 4)
                0: begin
                    in_gap_max    = 0;
                    out_stall_max = 0;
                end
                2: begin
                    // long receiver hold while the sender streams
                    in_gap_max    = 0;
                    out_stall_max = 12;
                    hold_req      = 80;
                end
                default: begin
                    in_gap_max    = 12;
                    out_stall_max = 12;
                end
            endcase
            repeat (PHASE_ITEMS) send_item(next_random_item(), 1'b0, NO_RES);
        end

        // zero lost limit ends the route on the next sample; stays done after
        in_gap_max    = 12;
        out_stall_max = 12;
        write_reg(CFG_LOST_LIMIT, 16'd0);
        repeat (60) send_item(next_random_item(), 1'b0, NO_RES);
        in_if.valid <= 1'b0;

        while (nav_expect_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("tb_three_sensor_line_follow_fsm: PASS");
        else
            $display("tb_three_sensor_line_follow_fsm: FAIL");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(5_000_000);
        $display("tb_three_sensor_line_follow_fsm: FAIL");
        $finish;
    end

endmodule
